>>> hw/rtl/mi3a_pkg.sv
// Package: shared types and constants for the 3x3 adjugate inverse core.
package mi3a_pkg;

  localparam int ElemW  = 16;
  localparam int ProdW  = 32;
  localparam int CofW   = 33;
  localparam int DetW   = 52;
  localparam int ThrW   = 51;
  localparam int InvW   = 32;
  localparam int MagW   = 51;   // |det| magnitude fits here
  localparam int NumW   = 57;   // |cof| << 24
  localparam int QW     = 33;   // quotient bits kept before saturation

  localparam logic [1:0] StatusInverted    = 2'd0;
  localparam logic [1:0] StatusSingular    = 2'd1;
  localparam logic [1:0] StatusUnsupported = 2'd2;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [CofW-1:0]  cof_t;
  typedef logic signed [DetW-1:0]  det_t;
  typedef logic signed [InvW-1:0]  inv_t;

  typedef struct packed {
    logic  mode;
    elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } mat_t;

  typedef struct packed {
    det_t       det_value;
    logic [1:0] status;
    inv_t       inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
  } res_t;

endpackage

>>> hw/rtl/mi3a_if.sv
// Interfaces: valid/ready channels for matrices and results.
interface mi3a_mat_if;
  logic           valid;
  logic           ready;
  mi3a_pkg::mat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mi3a_res_if;
  logic           valid;
  logic           ready;
  mi3a_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/mi3a_div.sv
// Pipelined restoring divider: one quotient bit per stage, with rounding and saturation.
module mi3a_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [mi3a_pkg::NumW-1:0]   num,
  input  logic [mi3a_pkg::MagW-1:0]   den,
  input  logic                        neg,
  output mi3a_pkg::inv_t              q
);
  localparam int NW = mi3a_pkg::NumW + 1;  // 2*num
  localparam int DW = mi3a_pkg::MagW + 1;  // 2*den
  localparam int QW = mi3a_pkg::QW;
  localparam int InvW = mi3a_pkg::InvW;

  function automatic mi3a_pkg::inv_t inv_min();
    return {1'b1, {(InvW-1){1'b0}}};
  endfunction
  function automatic mi3a_pkg::inv_t inv_max();
    return {1'b0, {(InvW-1){1'b1}}};
  endfunction

  // (2num+den)/(2den); quotient bits above QW collapse into a sticky overflow flag.
  logic [NW-1:0] n0;
  logic [DW-1:0] d0;
  assign n0 = {num, 1'b0} + NW'(den);
  assign d0 = {den, 1'b0};

  logic [NW-1:0] rem  [QW+1];
  logic [DW-1:0] dv   [QW+1];
  logic [QW-1:0] qacc [QW+1];
  logic          ovf  [QW+1];
  logic          ng   [QW+1];

  // Top quotient bits: any nonzero -> overflow. Check num2 >= den2 << QW.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= n0;
      dv[0]   <= d0;
      qacc[0] <= '0;
      ovf[0]  <= ({1'b0, n0} >= ({{(NW+QW-DW+1){1'b0}}, d0} << QW));
      ng[0]   <= neg;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_st
    localparam int Sh = QW - 1 - s;
    logic [NW+QW:0] trial;
    logic           take;
    assign trial = {{(QW+1){1'b0}}, dv[s]} << Sh;
    assign take  = {{(QW+1){1'b0}}, rem[s]} >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= take ? NW'({{(QW+1){1'b0}}, rem[s]} - trial) : rem[s];
        dv[s+1]   <= dv[s];
        qacc[s+1] <= {qacc[s][QW-2:0], take};
        ovf[s+1]  <= ovf[s];
        ng[s+1]   <= ng[s];
      end
    end
  end

  always_comb begin
    if (qacc[QW] == '0 && !ovf[QW]) begin
      q = '0;
    end else if (ng[QW]) begin
      if (ovf[QW] || qacc[QW] >= QW'(33'h080000000)) q = inv_min();
      else q = mi3a_pkg::inv_t'(-$signed({1'b0, qacc[QW][InvW-1:0]}));
    end else begin
      if (ovf[QW] || qacc[QW] > QW'(33'h07FFFFFFF)) q = inv_max();
      else q = mi3a_pkg::inv_t'(qacc[QW][InvW-1:0]);
    end
  end
endmodule

>>> hw/rtl/matrix_inverse_3x3_adjugate_core.sv
// Top level: determinant, classification and pipelined adjugate division.
//  channel | dir | handshake    | payload
//  mat     | in  | valid/ready  | mode, m00..m22
//  res     | out | valid/ready  | det_value, status, inv00..inv22
//  cfg     | in  | cfg_we       | singular_threshold (51 b)
// One matrix per cycle when not stalled; results pass the front stages, then the divider bit stages.
// The whole pipe advances when the output register is empty or taken.
// Reset clears valid bits and sets the threshold to 1.
module matrix_inverse_3x3_adjugate_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [mi3a_pkg::ThrW-1:0]    cfg_wdata,
  mi3a_mat_if.sink                     mat,
  mi3a_res_if.source                   res
);
  localparam int Lat = 5 + mi3a_pkg::QW + 1;

  logic [mi3a_pkg::ThrW-1:0] thr;
  always_ff @(posedge clk) begin
    if (rst) thr <= mi3a_pkg::ThrW'(1);
    else if (cfg_we) thr <= cfg_wdata;
  end

  logic en;
  logic [Lat-1:0] vld;
  assign en = !vld[Lat-1] || res.ready;
  assign mat.ready = en;
  assign res.valid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], mat.valid};
  end

  // stage 1: capture
  mi3a_pkg::mat_t s1;
  always_ff @(posedge clk) if (en) s1 <= mat.data;

  // stage 2: 2x2 minors (cofactors)
  mi3a_pkg::cof_t c [3][3];
  logic s2_mode;
  mi3a_pkg::elem_t s2_r0 [3];
  mi3a_pkg::elem_t a [3][3];
  assign a[0][0] = s1.m00; assign a[0][1] = s1.m01; assign a[0][2] = s1.m02;
  assign a[1][0] = s1.m10; assign a[1][1] = s1.m11; assign a[1][2] = s1.m12;
  assign a[2][0] = s1.m20; assign a[2][1] = s1.m21; assign a[2][2] = s1.m22;
  for (genvar i = 0; i < 3; i++) begin : g_ci
    for (genvar j = 0; j < 3; j++) begin : g_cj
      always_ff @(posedge clk) if (en)
        c[i][j] <= mi3a_pkg::cof_t'(a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3])
                 - mi3a_pkg::cof_t'(a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3]);
    end
  end
  logic signed [mi3a_pkg::CofW-1:0] d2x2;
  always_ff @(posedge clk) if (en) begin
    s2_mode <= s1.mode;
    s2_r0[0] <= s1.m00; s2_r0[1] <= s1.m01; s2_r0[2] <= s1.m02;
    d2x2 <= mi3a_pkg::cof_t'(s1.m00 * s1.m11) - mi3a_pkg::cof_t'(s1.m01 * s1.m10);
  end

  // stage 3: row-0 expansion products
  logic signed [mi3a_pkg::DetW-1:0] p [3];
  mi3a_pkg::cof_t c3 [3][3];
  logic s3_mode;
  logic signed [mi3a_pkg::CofW-1:0] d2x2_3;
  for (genvar j = 0; j < 3; j++) begin : g_p
    always_ff @(posedge clk) if (en)
      p[j] <= mi3a_pkg::DetW'(s2_r0[j] * c[0][j]);
  end
  always_ff @(posedge clk) if (en) begin
    c3 <= c; s3_mode <= s2_mode; d2x2_3 <= d2x2;
  end

  // stage 4: determinant (3x3, or the leading 2x2 minor shifted left by 8 when mode is 0)
  mi3a_pkg::det_t det4;
  mi3a_pkg::cof_t c4 [3][3];
  logic s4_mode;
  always_ff @(posedge clk) if (en) begin
    det4 <= s3_mode ? (p[0] + p[1] + p[2])
                    : mi3a_pkg::DetW'({{(mi3a_pkg::DetW-mi3a_pkg::CofW-8){d2x2_3[
                        mi3a_pkg::CofW-1]}}, d2x2_3, 8'd0});
    c4 <= c3; s4_mode <= s3_mode;
  end

  // stage 5: magnitude, classify
  logic [mi3a_pkg::MagW-1:0] dmag;
  logic [mi3a_pkg::DetW-1:0] dabs;
  assign dabs = det4[mi3a_pkg::DetW-1] ? -det4 : det4;
  logic [1:0] st5;
  mi3a_pkg::det_t det5;
  logic dneg5;
  mi3a_pkg::cof_t c5 [3][3];
  always_ff @(posedge clk) if (en) begin
    dmag <= mi3a_pkg::MagW'(dabs);
    dneg5 <= det4[mi3a_pkg::DetW-1];
    det5 <= det4; c5 <= c4;
    if (dabs <= {1'b0, thr}) st5 <= mi3a_pkg::StatusSingular;
    else if (!s4_mode) st5 <= mi3a_pkg::StatusUnsupported;
    else st5 <= mi3a_pkg::StatusInverted;
  end

  // divider lanes: inv[j][i] = C[i][j] / det
  mi3a_pkg::inv_t qv [3][3];
  logic [mi3a_pkg::MagW-1:0] dsafe;
  assign dsafe = (dmag == '0) ? mi3a_pkg::MagW'(1) : dmag;
  for (genvar i = 0; i < 3; i++) begin : g_di
    for (genvar j = 0; j < 3; j++) begin : g_dj
      logic [mi3a_pkg::CofW-1:0] cm;
      assign cm = c5[i][j][mi3a_pkg::CofW-1] ? -c5[i][j] : c5[i][j];
      mi3a_div u_div (
        .clk (clk), .en (en),
        .num ({cm, 24'd0}),
        .den (dsafe),
        .neg (c5[i][j][mi3a_pkg::CofW-1] != dneg5),
        .q   (qv[j][i])
      );
    end
  end

  // status and det ride alongside the divider
  localparam int DD = mi3a_pkg::QW + 1;
  logic [1:0]      st_d  [DD];
  mi3a_pkg::det_t  det_d [DD];
  always_ff @(posedge clk) if (en) begin
    st_d[0] <= st5; det_d[0] <= det5;
    for (int k = 1; k < DD; k++) begin
      st_d[k] <= st_d[k-1]; det_d[k] <= det_d[k-1];
    end
  end

  logic ok;
  assign ok = st_d[DD-1] == mi3a_pkg::StatusInverted;
  always_comb begin
    res.data.det_value = det_d[DD-1];
    res.data.status    = st_d[DD-1];
    res.data.inv00 = ok ? qv[0][0] : '0;
    res.data.inv01 = ok ? qv[0][1] : '0;
    res.data.inv02 = ok ? qv[0][2] : '0;
    res.data.inv10 = ok ? qv[1][0] : '0;
    res.data.inv11 = ok ? qv[1][1] : '0;
    res.data.inv12 = ok ? qv[1][2] : '0;
    res.data.inv20 = ok ? qv[2][0] : '0;
    res.data.inv21 = ok ? qv[2][1] : '0;
    res.data.inv22 = ok ? qv[2][2] : '0;
  end
endmodule

>>> hw/rtl/mi3a_checker.sv
// Checker: port-level assertions for the adjugate core, bound to the top level.
module mi3a_checker (
  input logic           clk,
  input logic           rst,
  input logic           mat_ready,
  input logic           res_valid,
  input logic           res_ready,
  input mi3a_pkg::res_t res_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data)) else $error("result dropped");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status != mi3a_pkg::StatusInverted |->
    res_data.inv00 == '0 && res_data.inv22 == '0) else $error("inverse not cleared");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.status != 2'd3) else $error("bad status");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> mat_ready) else $error("stalled while empty");
endmodule

bind matrix_inverse_3x3_adjugate_core mi3a_checker u_chk (
  .clk(clk), .rst(rst), .mat_ready(mat.ready), .res_valid(res.valid),
  .res_ready(res.ready), .res_data(res.data));
